### hdl/nrbe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the divide-by-fifteen helper for the RGB565
// coverage blend expander. No dependencies.
package nrbe_pkg;

  localparam int unsigned LevelW   = 4;
  localparam int unsigned PixelW   = 16;
  localparam int unsigned SumW     = 10;
  localparam int unsigned RedW     = 5;
  localparam int unsigned GreenW   = 6;
  localparam int unsigned BlueW    = 5;
  localparam int unsigned RecipW   = 12;
  localparam int unsigned RecipSh  = 15;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [LevelW-1:0] LevelMax  = 4'd15;
  localparam logic [RecipW-1:0] Recip15   = 12'd2185;
  localparam logic [PixelW-1:0] RedMask   = 16'hF800;
  localparam logic [PixelW-1:0] GreenMask = 16'h07E0;
  localparam logic [PixelW-1:0] BlueMask  = 16'h001F;
  localparam logic [PixelW-1:0] FgReset   = 16'hFFFF;
  localparam logic [PixelW-1:0] BgReset   = 16'h0000;

  localparam logic [AddrW-1:0] AddrFgColor = 3'd0;
  localparam logic [AddrW-1:0] AddrBgColor = 3'd4;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sum_t;

  // Exact for every weighted sum up to 63 * 15.
  function automatic logic [GreenW-1:0] div15(input logic [SumW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(Recip15);
    return prod[RecipSh +: GreenW];
  endfunction

endpackage

### hdl/nrbe_lane.sv
`timescale 1ns / 1ps
// One blend lane: weighted channel sums for one coverage level, registered,
// then the divide by fifteen and RGB565 repack. Depends on nrbe_pkg.
module nrbe_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [nrbe_pkg::LevelW-1:0]    level_i,
  input  logic [nrbe_pkg::PixelW-1:0]    fg_i,
  input  logic [nrbe_pkg::PixelW-1:0]    bg_i,
  output logic [nrbe_pkg::PixelW-1:0]    pixel_o
);

  logic [nrbe_pkg::LevelW-1:0] inv_level;
  nrbe_pkg::sum_t              sum_d;
  nrbe_pkg::sum_t              sum_q;
  logic [nrbe_pkg::GreenW-1:0] red;
  logic [nrbe_pkg::GreenW-1:0] green;
  logic [nrbe_pkg::GreenW-1:0] blue;

  assign inv_level = nrbe_pkg::LevelMax - level_i;

  always_comb begin
    sum_d.red   = nrbe_pkg::SumW'(fg_i[15:11]) * nrbe_pkg::SumW'(level_i)
                + nrbe_pkg::SumW'(bg_i[15:11]) * nrbe_pkg::SumW'(inv_level);
    sum_d.green = nrbe_pkg::SumW'(fg_i[10:5]) * nrbe_pkg::SumW'(level_i)
                + nrbe_pkg::SumW'(bg_i[10:5]) * nrbe_pkg::SumW'(inv_level);
    sum_d.blue  = nrbe_pkg::SumW'(fg_i[4:0]) * nrbe_pkg::SumW'(level_i)
                + nrbe_pkg::SumW'(bg_i[4:0]) * nrbe_pkg::SumW'(inv_level);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign red   = nrbe_pkg::div15(sum_q.red);
  assign green = nrbe_pkg::div15(sum_q.green);
  assign blue  = nrbe_pkg::div15(sum_q.blue);

  assign pixel_o = {red[nrbe_pkg::RedW-1:0], green, blue[nrbe_pkg::BlueW-1:0]};

endmodule

### hdl/nibble_rgb565_blend_expander.sv
`timescale 1ns / 1ps
// Top level: configuration registers, two blend lanes and the output register.
// Depends on nrbe_pkg and nrbe_lane.
// Input transactions pass through the weighted-sum register, then the divide,
// repack and output register.
// Throughput is one byte (two pixels) per cycle; the pipeline stalls only
// while a finished result waits on m_axis_tready.
// Reset clears the valid flags and loads fg_color = 0xFFFF, bg_color = 0x0000.
module nibble_rgb565_blend_expander (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] packed_levels
  input  logic [7:0]                    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] first_pixel, [31:16] second_pixel
  output logic [31:0]                   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrbe_pkg::AddrW-1:0]    paddr,
  input  logic [nrbe_pkg::DataW-1:0]    pwdata,
  output logic [nrbe_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [nrbe_pkg::PixelW-1:0] fg_q;
  logic [nrbe_pkg::PixelW-1:0] bg_q;
  logic                        cfg_wr;
  logic                        pipe_en;
  logic                        s1_valid_q;
  logic                        m_valid_q;
  logic [nrbe_pkg::PixelW-1:0] first_pix;
  logic [nrbe_pkg::PixelW-1:0] second_pix;
  logic [31:0]                 m_data_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= nrbe_pkg::FgReset;
      bg_q <= nrbe_pkg::BgReset;
    end else if (cfg_wr) begin
      if (paddr == nrbe_pkg::AddrFgColor) begin
        fg_q <= pwdata[nrbe_pkg::PixelW-1:0];
      end else if (paddr == nrbe_pkg::AddrBgColor) begin
        bg_q <= pwdata[nrbe_pkg::PixelW-1:0];
      end
    end
  end

  always_comb begin
    case (paddr)
      nrbe_pkg::AddrFgColor: prdata = nrbe_pkg::DataW'(fg_q);
      nrbe_pkg::AddrBgColor: prdata = nrbe_pkg::DataW'(bg_q);
      default:               prdata = '0;
    endcase
  end

  assign pipe_en       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  nrbe_lane u_lane_first (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .level_i (s_axis_tdata[7:4]),
    .fg_i    (fg_q),
    .bg_i    (bg_q),
    .pixel_o (first_pix)
  );

  nrbe_lane u_lane_second (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .level_i (s_axis_tdata[3:0]),
    .fg_i    (fg_q),
    .bg_i    (bg_q),
    .pixel_o (second_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= s_axis_tvalid;
      m_valid_q  <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_data_q <= {second_pix, first_pix};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && pipe_en |=> m_valid_q)
    else $error("stage one result was dropped");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> s1_valid_q == $past(s1_valid_q))
    else $error("stage one valid changed during stall");

endmodule

### bench/nrbe_blend_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB565 coverage blend expander: watches the stream and APB
// channels, predicts each pixel pair and compares it. Depends on nrbe_pkg.
module nrbe_blend_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [31:0]                  m_tdata_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [nrbe_pkg::AddrW-1:0]   paddr_i,
  input  logic [nrbe_pkg::DataW-1:0]   pwdata_i,
  input  logic [nrbe_pkg::DataW-1:0]   prdata_i,
  input  logic                         pready_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic [nrbe_pkg::PixelW-1:0] second;
    logic [nrbe_pkg::PixelW-1:0] first;
  } pixel_pair_t;

  logic [nrbe_pkg::PixelW-1:0] fg_color_q;
  logic [nrbe_pkg::PixelW-1:0] bg_color_q;
  pixel_pair_t                 pixel_pair_q[$];
  pixel_pair_t                 want;
  pixel_pair_t                 got;
  logic [nrbe_pkg::DataW-1:0]  reg_value;
  int                          mismatches;

  function automatic logic [nrbe_pkg::PixelW-1:0] blend_pixel(
    input logic [nrbe_pkg::PixelW-1:0] fg,
    input logic [nrbe_pkg::PixelW-1:0] bg,
    input logic [nrbe_pkg::LevelW-1:0] level);
    int unsigned k;
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    k = level;
    red   = (int'(fg[15:11]) * k + int'(bg[15:11]) * (15 - k)) / 15;
    green = (int'(fg[10:5]) * k + int'(bg[10:5]) * (15 - k)) / 15;
    blue  = (int'(fg[4:0]) * k + int'(bg[4:0]) * (15 - k)) / 15;
    return {red[nrbe_pkg::RedW-1:0], green[nrbe_pkg::GreenW-1:0],
            blue[nrbe_pkg::BlueW-1:0]};
  endfunction

  initial begin
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q = nrbe_pkg::FgReset;
      bg_color_q = nrbe_pkg::BgReset;
      pixel_pair_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (pixel_pair_q.size() == 0) begin
          $display("%0t: unexpected pixel pair, expected none, actual %h", $realtime, got);
          mismatches++;
        end else begin
          want = pixel_pair_q.pop_front();
          if (got.first !== want.first) begin
            $display("%0t: first_pixel mismatch, expected %h, actual %h",
                     $realtime, want.first, got.first);
            mismatches++;
          end
          if (got.second !== want.second) begin
            $display("%0t: second_pixel mismatch, expected %h, actual %h",
                     $realtime, want.second, got.second);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want.first  = blend_pixel(fg_color_q, bg_color_q, s_tdata_i[7:4]);
        want.second = blend_pixel(fg_color_q, bg_color_q, s_tdata_i[3:0]);
        pixel_pair_q.push_back(want);
      end
      if (psel_i && penable_i && pready_i && (paddr_i == nrbe_pkg::AddrFgColor ||
                                              paddr_i == nrbe_pkg::AddrBgColor)) begin
        if (pwrite_i) begin
          if (paddr_i == nrbe_pkg::AddrFgColor) begin
            fg_color_q = pwdata_i[nrbe_pkg::PixelW-1:0];
          end else begin
            bg_color_q = pwdata_i[nrbe_pkg::PixelW-1:0];
          end
        end else begin
          reg_value = (paddr_i == nrbe_pkg::AddrFgColor) ?
                      nrbe_pkg::DataW'(fg_color_q) : nrbe_pkg::DataW'(bg_color_q);
          if (prdata_i !== reg_value) begin
            $display("%0t: register read mismatch at %h, expected %h, actual %h",
                     $realtime, paddr_i, reg_value, prdata_i);
            mismatches++;
          end
        end
      end
    end
    pending_o    <= pixel_pair_q.size();
    fail_count_o <= mismatches;
  end

endmodule

### bench/tb_nibble_rgb565_blend_expander.sv
`timescale 1ns / 1ps
// Testbench top for the RGB565 coverage blend expander: clock, reset, stream
// and APB stimulus, and the verdict. Depends on nrbe_pkg, nibble_rgb565_blend_expander and nrbe_blend_checker.
module tb_nibble_rgb565_blend_expander;

  localparam int unsigned Segments     = 12;
  localparam int unsigned SegmentItems = 158;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [nrbe_pkg::AddrW-1:0]    paddr;
  logic [nrbe_pkg::DataW-1:0]    pwdata;
  logic [nrbe_pkg::DataW-1:0]    prdata;
  logic                          pready;

  int fail_count;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;

  nibble_rgb565_blend_expander dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  nrbe_blend_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_levels(input logic [7:0] levels);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= levels;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_pixels;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [nrbe_pkg::AddrW-1:0] addr,
                            input logic [nrbe_pkg::PixelW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_colors(input logic [nrbe_pkg::PixelW-1:0] fg,
                            input logic [nrbe_pkg::PixelW-1:0] bg);
    apb_access(1'b1, nrbe_pkg::AddrFgColor, fg);
    apb_access(1'b1, nrbe_pkg::AddrBgColor, bg);
    apb_access(1'b0, nrbe_pkg::AddrFgColor, '0);
    apb_access(1'b0, nrbe_pkg::AddrBgColor, '0);
  endtask

  initial begin
    #2_000_000;
    $display("tb_nibble_rgb565_blend_expander: FAIL");
    $finish;
  end

  initial begin
    logic [nrbe_pkg::PixelW-1:0] fg;
    logic [nrbe_pkg::PixelW-1:0] bg;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_idle_pct   = 32;
    rx_idle_pct   = 65;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset colors first: white over black, including both full levels.
    apb_access(1'b0, nrbe_pkg::AddrFgColor, '0);
    apb_access(1'b0, nrbe_pkg::AddrBgColor, '0);
    send_levels(8'h00);
    send_levels(8'hFF);
    send_levels(8'hF0);
    send_levels(8'h0F);
    send_levels(8'h5A);
    send_levels(8'hA5);
    send_levels(8'h18);
    send_levels(8'h81);
    send_levels(8'h7E);
    send_levels(8'hE7);
    drain_pixels();

    // Inverted colors, written with junk in the upper data bits.
    set_colors(16'h0000, 16'hFFFF);
    send_levels(8'h0F);
    send_levels(8'hF0);
    send_levels(8'h88);
    send_levels(8'hC3);
    drain_pixels();

    // Channels pulling in opposite directions.
    set_colors(16'hF81F, 16'h07E0);
    send_levels(8'h00);
    send_levels(8'hFF);
    send_levels(8'h69);
    send_levels(8'h96);
    send_levels(8'h4B);
    send_levels(8'hB4);
    drain_pixels();

    for (int seg = 0; seg < Segments; seg++) begin
      case (seg / 4)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          fg = 16'hFFFF;
          bg = 16'h0000;
        end
        1: begin
          fg = 16'h0000;
          bg = 16'hFFFF;
        end
        2: begin
          fg = 16'hFFFF;
          bg = 16'hFFFF;
        end
        3: begin
          fg = 16'h0000;
          bg = 16'h0000;
        end
        4: begin
          fg = 16'hF800;
          bg = 16'h07E0;
        end
        5: begin
          fg = 16'h001F;
          bg = 16'hF81F;
        end
        default: begin
          fg = 16'($urandom);
          bg = 16'($urandom);
        end
      endcase
      set_colors(fg, bg);
      for (int n = 0; n < SegmentItems; n++) begin
        send_levels(8'($urandom));
      end
      drain_pixels();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_nibble_rgb565_blend_expander: PASS");
    end else begin
      $display("tb_nibble_rgb565_blend_expander: FAIL");
    end
    $finish;
  end

endmodule
